FILE: rtl/pstcc_pkg.sv
// Shared types and constants for the path space-time collision check.
package pstcc_pkg;

    localparam int COORD_W  = 24;
    localparam int STAMP_W  = 48;
    localparam int DIST_W   = 50;
    localparam int CFG_W    = 50;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD_SQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW       = 1'd1;

    // Register reset values
    localparam logic [DIST_W-1:0]  DIST_THRESHOLD_SQ_RST = 50'd9664;
    localparam logic [STAMP_W-1:0] TIME_WINDOW_RST       = 48'd627000;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                       command;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic        [STAMP_W-1:0]  stamp;
    } pose_in_t;

    typedef struct packed {
        logic                       collision_found;
        logic signed [COORD_W-1:0]  first_x;
        logic signed [COORD_W-1:0]  first_y;
        logic        [STAMP_W-1:0]  first_stamp;
        logic signed [COORD_W-1:0]  last_x;
        logic signed [COORD_W-1:0]  last_y;
        logic        [STAMP_W-1:0]  last_stamp;
        logic                       store_overflowed;
    } report_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic        [STAMP_W-1:0]  stamp;
    } pose_t;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } pair_status_t;

endpackage

FILE: rtl/pstcc_pair_unit.sv
// Three-stage pipeline that tests one query/reference pose pair per cycle.
module pstcc_pair_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  pstcc_pkg::pose_t                  query,
    input  pstcc_pkg::pose_t                  ref_pose,
    input  logic [pstcc_pkg::DIST_W-1:0]      dist_thr,
    input  logic [pstcc_pkg::STAMP_W-1:0]     time_win,
    output pstcc_pkg::pair_status_t           status
);
    import pstcc_pkg::*;

    localparam int DX_W = COORD_W + 1;
    localparam int SQ_W = 2 * COORD_W + 1;

    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic signed [DX_W-1:0]  dx_reg;
    logic signed [DX_W-1:0]  dy_reg;
    logic [STAMP_W-1:0]      dt_reg;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic                    time_ok_reg;
    logic                    hit_reg;

    logic signed [DX_W-1:0]   dx_next;
    logic signed [DX_W-1:0]   dy_next;
    logic [STAMP_W-1:0]       dt_next;
    logic signed [2*DX_W-1:0] prod_x;
    logic signed [2*DX_W-1:0] prod_y;
    logic [DIST_W-1:0]        d2_sum;

    // Differences: positions widened by one bit, time as absolute difference
    always_comb
    begin
        dx_next = DX_W'(query.x) - DX_W'(ref_pose.x);
        dy_next = DX_W'(query.y) - DX_W'(ref_pose.y);
        if (query.stamp >= ref_pose.stamp)
            dt_next = query.stamp - ref_pose.stamp;
        else
            dt_next = ref_pose.stamp - query.stamp;
    end

    // Squares are nonnegative and fit in SQ_W bits
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign d2_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    // Advance stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dt_reg      <= dt_next;
        sqx_reg     <= prod_x[SQ_W-1:0];
        sqy_reg     <= prod_y[SQ_W-1:0];
        time_ok_reg <= (dt_reg < time_win);
        hit_reg     <= (d2_sum < dist_thr) && time_ok_reg;
    end

    assign status.busy      = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign status.hit_valid = s3_valid_reg;
    assign status.hit       = hit_reg;

endmodule

FILE: rtl/path_space_time_collision_check_core.sv
// Top level of the path space-time collision check: pose store, scan control, tracking.
//
//   channel  direction  handshake                  payload
//   pose     in         pose_valid / pose_ready    pose   (pstcc_pkg::pose_in_t)
//   report   out        report_valid / report_ready report (pstcc_pkg::report_t)
//   cfg      in         cfg_we (no wait)           cfg_index, cfg_data
//
// A check reads the store one entry per cycle, then waits until the pair pipeline drains;
// with an empty store it does not scan. The single-port read of the pose memory sets the
// scan rate. Reset (rst_n, async, low) empties the store and the tracking; memory contents
// are not cleared. Every command waits while a scan runs; a finish also waits while
// an earlier report is held and not taken in the same cycle.
module path_space_time_collision_check_core #(
    parameter int MAX_REF_POSES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pose_valid,
    output logic                                pose_ready,
    input  pstcc_pkg::pose_in_t                 pose,
    output logic                                report_valid,
    input  logic                                report_ready,
    output pstcc_pkg::report_t                  report,
    input  logic                                cfg_we,
    input  logic [pstcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pstcc_pkg::CFG_W-1:0]         cfg_data
);
    import pstcc_pkg::*;

    localparam int AW = (MAX_REF_POSES > 1) ? $clog2(MAX_REF_POSES) : 1;
    localparam int CW = $clog2(MAX_REF_POSES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      ref_count_reg;
    logic [CW-1:0]      scan_idx_reg;
    logic               overflow_reg;
    logic               any_hit_reg;
    logic               hit_acc_reg;
    pose_t              first_reg;
    pose_t              last_reg;
    logic               rd_valid_reg;
    pose_t              rd_data_reg;
    pose_t              query_reg;
    logic               report_valid_reg;
    report_t            report_reg;
    logic [DIST_W-1:0]  dist_thr_reg;
    logic [STAMP_W-1:0] time_win_reg;

    pose_t              mem [MAX_REF_POSES];

    logic               pose_fire;
    logic               store_full;
    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    pose_t              pose_entry;
    logic               scan_last;
    pair_status_t       pair_status;

    assign store_full = (ref_count_reg >= CW'(MAX_REF_POSES));
    assign pose_ready = (state_reg == ST_IDLE)
                     && ((pose.command != CMD_FINISH) || !report_valid_reg || report_ready);
    assign pose_fire  = pose_valid && pose_ready;
    assign mem_we     = pose_fire && (pose.command == CMD_APPEND) && !store_full;
    assign rd_addr    = scan_idx_reg[AW-1:0];
    assign scan_last  = (CW'(scan_idx_reg + 1'b1) == ref_count_reg);

    assign pose_entry.x     = pose.pos_x;
    assign pose_entry.y     = pose.pos_y;
    assign pose_entry.stamp = pose.stamp;

    // Pose memory: write on append, read one entry per cycle during a scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[ref_count_reg[AW-1:0]] <= pose_entry;
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_thr_reg <= DIST_THRESHOLD_SQ_RST;
            time_win_reg <= TIME_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIST_THRESHOLD_SQ: dist_thr_reg <= cfg_data[DIST_W-1:0];
                CFG_TIME_WINDOW:       time_win_reg <= cfg_data[STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the query pose during its scan
    always_ff @(posedge clk)
    begin
        if (pose_fire && (pose.command == CMD_CHECK))
            query_reg <= pose_entry;
    end

    // Command sequencer, scan control, collision tracking and report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ref_count_reg    <= '0;
            scan_idx_reg     <= '0;
            overflow_reg     <= 1'b0;
            any_hit_reg      <= 1'b0;
            hit_acc_reg      <= 1'b0;
            first_reg        <= '0;
            last_reg         <= '0;
            rd_valid_reg     <= 1'b0;
            report_valid_reg <= 1'b0;
            report_reg       <= '0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_SCAN);

            // Drop the report once it is taken, unless a finish reloads it
            if (report_valid_reg && report_ready
                && !(pose_fire && (pose.command == CMD_FINISH)))
                report_valid_reg <= 1'b0;

            // Accumulate pair results
            if (pair_status.hit_valid && pair_status.hit)
                hit_acc_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pose_fire)
                    begin
                        unique case (pose.command)
                            CMD_CLEAR:
                            begin
                                ref_count_reg <= '0;
                                overflow_reg  <= 1'b0;
                            end
                            CMD_APPEND:
                            begin
                                if (store_full)
                                    overflow_reg <= 1'b1;
                                else
                                    ref_count_reg <= CW'(ref_count_reg + 1'b1);
                            end
                            CMD_CHECK:
                            begin
                                scan_idx_reg <= '0;
                                hit_acc_reg  <= 1'b0;
                                if (ref_count_reg != '0)
                                    state_reg <= ST_SCAN;
                            end
                            CMD_FINISH:
                            begin
                                report_valid_reg            <= 1'b1;
                                report_reg.collision_found  <= any_hit_reg;
                                report_reg.first_x          <= first_reg.x;
                                report_reg.first_y          <= first_reg.y;
                                report_reg.first_stamp      <= first_reg.stamp;
                                report_reg.last_x           <= last_reg.x;
                                report_reg.last_y           <= last_reg.y;
                                report_reg.last_stamp       <= last_reg.stamp;
                                report_reg.store_overflowed <= overflow_reg;
                                any_hit_reg                 <= 1'b0;
                                first_reg                   <= '0;
                                last_reg                    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                        state_reg <= ST_DRAIN;
                    else
                        scan_idx_reg <= CW'(scan_idx_reg + 1'b1);
                end
                ST_DRAIN:
                begin
                    // All pair results are in once read and pipeline are empty
                    if (!rd_valid_reg && !pair_status.busy)
                    begin
                        if (hit_acc_reg)
                        begin
                            if (!any_hit_reg)
                                first_reg <= query_reg;
                            last_reg    <= query_reg;
                            any_hit_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    pstcc_pair_unit u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .query    (query_reg),
        .ref_pose (rd_data_reg),
        .dist_thr (dist_thr_reg),
        .time_win (time_win_reg),
        .status   (pair_status)
    );

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the path space-time collision check core.
module tb;
    import pstcc_pkg::*;

    localparam int MAX_POSES   = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 88;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

    // Predicts reports from accepted pose transfers and checks the report channel
    class collision_scoreboard;
        pose_t              ref_store[MAX_POSES];
        int unsigned        store_count;
        bit                 any_hit;
        bit                 overflow;
        pose_t              first_hit;
        pose_t              last_hit;
        logic [DIST_W-1:0]  dist_limit;
        logic [STAMP_W-1:0] window;
        report_t            expected_reports[$];
        int                 errors;
        int                 checks;
        int                 hits;
        int                 reports;

        function new();
            store_count = 0;
            any_hit     = 1'b0;
            overflow    = 1'b0;
            first_hit   = '0;
            last_hit    = '0;
            dist_limit  = DIST_THRESHOLD_SQ_RST;
            window      = TIME_WINDOW_RST;
            errors      = 0;
            checks      = 0;
            hits        = 0;
            reports     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DIST_THRESHOLD_SQ: dist_limit = data[DIST_W-1:0];
                CFG_TIME_WINDOW:       window     = data[STAMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pose(pose_in_t p);
            logic signed [63:0] dx;
            logic signed [63:0] dy;
            logic [63:0]        d2;
            logic [STAMP_W-1:0] dt;
            bit                 hit;
            pose_t              q;
            report_t            r;
            q.x     = p.pos_x;
            q.y     = p.pos_y;
            q.stamp = p.stamp;
            case (p.command)
                CMD_CLEAR:
                begin
                    store_count = 0;
                    overflow    = 1'b0;
                end
                CMD_APPEND:
                begin
                    // Drop the pose and flag it once the store is full
                    if (store_count < MAX_POSES)
                    begin
                        ref_store[store_count] = q;
                        store_count++;
                    end
                    else
                        overflow = 1'b1;
                end
                CMD_CHECK:
                begin
                    // Scan the stored poses until one is near in space and time
                    hit = 1'b0;
                    checks++;
                    for (int k = 0; k < store_count && !hit; k++)
                    begin
                        dx = $signed(p.pos_x) - $signed(ref_store[k].x);
                        dy = $signed(p.pos_y) - $signed(ref_store[k].y);
                        d2 = dx * dx + dy * dy;
                        dt = (p.stamp >= ref_store[k].stamp) ? p.stamp - ref_store[k].stamp
                                                             : ref_store[k].stamp - p.stamp;
                        if (d2 < dist_limit && dt < window)
                            hit = 1'b1;
                    end
                    if (hit)
                    begin
                        hits++;
                        if (!any_hit)
                            first_hit = q;
                        last_hit = q;
                        any_hit  = 1'b1;
                    end
                end
                default:
                begin
                    // Finish: report the tracking, then clear it
                    r.collision_found  = any_hit;
                    r.first_x          = first_hit.x;
                    r.first_y          = first_hit.y;
                    r.first_stamp      = first_hit.stamp;
                    r.last_x           = last_hit.x;
                    r.last_y           = last_hit.y;
                    r.last_stamp       = last_hit.stamp;
                    r.store_overflowed = overflow;
                    expected_reports = {expected_reports, r};
                    any_hit   = 1'b0;
                    first_hit = '0;
                    last_hit  = '0;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("report transfer with no finish pending");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            reports++;
            compare_field("collision_found", want.collision_found, got.collision_found);
            compare_field("first_x", want.first_x, got.first_x);
            compare_field("first_y", want.first_y, got.first_y);
            compare_field("first_stamp", want.first_stamp, got.first_stamp);
            compare_field("last_x", want.last_x, got.last_x);
            compare_field("last_y", want.last_y, got.last_y);
            compare_field("last_stamp", want.last_stamp, got.last_stamp);
            compare_field("store_overflowed", want.store_overflowed, got.store_overflowed);
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 pose_valid   = 1'b0;
    logic                 pose_ready;
    pose_in_t             pose         = '0;
    logic                 report_valid;
    logic                 report_ready = 1'b0;
    report_t              report;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    collision_scoreboard sb = new();

    int tx_idle_pct   = 19;
    int rx_idle_pct   = 72;
    int items_sent    = 0;
    int cycle_count   = 0;
    int settings_used = 1;

    path_space_time_collision_check_core #(
        .MAX_REF_POSES(MAX_POSES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pose_valid   (pose_valid),
        .pose_ready   (pose_ready),
        .pose         (pose),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the report channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            report_ready <= 1'b0;
        else
            report_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check each report transfer
    always @(posedge clk)
    begin
        if (rst_n && report_valid && report_ready)
            sb.check_report(report);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic pose_in_t make_pose(cmd_t c, logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y, logic [STAMP_W-1:0] t);
        pose_in_t p;
        p.command = c;
        p.pos_x   = x;
        p.pos_y   = y;
        p.stamp   = t;
        return p;
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[STAMP_W-1:0];
    endfunction

    // Offset a coordinate by up to +/- span, wrapping at 24 bits
    function automatic logic [COORD_W-1:0] jitter_coord(logic [COORD_W-1:0] c,
                                                        int unsigned span);
        return c + 24'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [STAMP_W-1:0] jitter_stamp(logic [STAMP_W-1:0] c,
                                                        int unsigned span);
        return c + 48'($urandom_range(0, 2 * span)) - 48'(span);
    endfunction

    // Hold valid until the transfer, then maybe leave a gap
    task automatic send_pose(input pose_in_t p);
        pose_valid <= 1'b1;
        pose       <= p;
        do @(posedge clk); while (!pose_ready);
        sb.note_pose(p);
        items_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pose_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    // Drain all reports and let the last scan finish
    task automatic wait_idle();
        pose_valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (sb.store_count + 20) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Extremes, boundaries of both limits, empty store and clear behavior
    task automatic run_directed();
        send_pose(make_pose(CMD_FINISH, '0, '0, '0));
        send_pose(make_pose(CMD_CHECK, '0, '0, '0));
        send_pose(make_pose(CMD_APPEND, COORD_MAX, COORD_MAX, STAMP_MAX));
        send_pose(make_pose(CMD_APPEND, COORD_MIN, COORD_MIN, '0));
        send_pose(make_pose(CMD_APPEND, 24'(1000), 24'(-2000), 48'd5000000));
        send_pose(make_pose(CMD_CHECK, COORD_MIN, COORD_MIN, '0));
        send_pose(make_pose(CMD_CHECK, 24'(1098), 24'(-2000), 48'd5000000));
        send_pose(make_pose(CMD_CHECK, 24'(1099), 24'(-2000), 48'd5000000));
        send_pose(make_pose(CMD_CHECK, 24'(1098), 24'(-1992), 48'd5000000));
        send_pose(make_pose(CMD_CHECK, 24'(1098), 24'(-1993), 48'd5000000));
        send_pose(make_pose(CMD_CHECK, 24'(1000), 24'(-2000), 48'd5627000));
        send_pose(make_pose(CMD_CHECK, 24'(1000), 24'(-2000), 48'd4373001));
        send_pose(make_pose(CMD_CHECK, COORD_MAX, COORD_MAX, STAMP_MAX));
        send_pose(make_pose(CMD_CHECK, COORD_MAX, COORD_MIN, '0));
        send_pose(make_pose(CMD_FINISH, '0, '0, '0));
        send_pose(make_pose(CMD_FINISH, '0, '0, '0));
        send_pose(make_pose(CMD_CHECK, 24'(1000), 24'(-2000), 48'd5000000));
        send_pose(make_pose(CMD_CLEAR, '0, '0, '0));
        send_pose(make_pose(CMD_CHECK, 24'(1000), 24'(-2000), 48'd5000000));
        send_pose(make_pose(CMD_FINISH, '0, '0, '0));
    endtask

    // Maybe clear, build a small clustered path, query around it, maybe finish
    task automatic pose_sequence(input int unsigned span_xy, input int unsigned span_t);
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [STAMP_W-1:0] ct;
        int unsigned        chk_xy;
        int unsigned        chk_t;
        cx     = 24'($urandom());
        cy     = 24'($urandom());
        ct     = rand_stamp();
        chk_xy = (span_xy > 4194303) ? 8388607 : 2 * span_xy;
        chk_t  = 2 * span_t;
        if ($urandom_range(0, 99) < 80)
            send_pose(make_pose(CMD_CLEAR, '0, '0, '0));
        repeat ($urandom_range(1, 8))
            send_pose(make_pose(CMD_APPEND, jitter_coord(cx, span_xy), jitter_coord(cy, span_xy),
                                jitter_stamp(ct, span_t)));
        repeat ($urandom_range(1, 6))
            send_pose(make_pose(CMD_CHECK, jitter_coord(cx, chk_xy), jitter_coord(cy, chk_xy),
                                jitter_stamp(ct, chk_t)));
        if ($urandom_range(0, 99) < 90)
            send_pose(make_pose(CMD_FINISH, '0, '0, '0));
    endtask

    task automatic run_phase(input int ph);
        logic [DIST_W-1:0]  dist_sq;
        logic [STAMP_W-1:0] win;
        int unsigned        span_xy;
        int unsigned        span_t;
        int                 goal;
        case (ph)
            0:       begin dist_sq = DIST_THRESHOLD_SQ_RST; win = TIME_WINDOW_RST;
                           span_xy = 100; span_t = 600000; end
            1:       begin dist_sq = 50'd100; win = 48'd1000; span_xy = 10; span_t = 1000; end
            2:       begin dist_sq = '0; win = STAMP_MAX; span_xy = 8; span_t = 1000; end
            3:       begin dist_sq = DIST_MAX; win = '0; span_xy = 8; span_t = 4; end
            4:       begin dist_sq = DIST_MAX; win = STAMP_MAX;
                           span_xy = 8388607; span_t = 1073741823; end
            default: begin span_xy = $urandom_range(1, 40000);
                           dist_sq = 50'(span_xy * span_xy);
                           span_t = $urandom_range(1, 536870912); win = 48'(span_t); end
        endcase
        // Receiver idles first, then the sender, then neither
        tx_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 72 : 0;
        rx_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 19 : 0;
        wait_idle();
        cfg_write(CFG_DIST_THRESHOLD_SQ, dist_sq);
        cfg_write(CFG_TIME_WINDOW, {2'($urandom()), win});
        settings_used++;
        if (ph == 4)
        begin
            // Full-scale window: a time gap of exactly the window does not collide
            send_pose(make_pose(CMD_CLEAR, '0, '0, '0));
            send_pose(make_pose(CMD_APPEND, '0, '0, '0));
            send_pose(make_pose(CMD_CHECK, '0, '0, STAMP_MAX));
            send_pose(make_pose(CMD_CHECK, COORD_MAX, COORD_MIN, STAMP_MAX - 1));
            send_pose(make_pose(CMD_FINISH, '0, '0, '0));
        end
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 99) < 80)
                pose_sequence(span_xy, span_t);
            else
                send_pose(make_pose(cmd_t'($urandom_range(0, 3)), 24'($urandom()),
                                    24'($urandom()), rand_stamp()));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int ph = 0; ph < 6; ph++)
            run_phase(ph);
        wait_idle();
        $display("Ran %0d pose transfers: %0d checks, %0d colliding, %0d reports checked",
                 items_sent, sb.checks, sb.hits, sb.reports);
        $display("Limits covered %0d register settings, including zero and full scale",
                 settings_used);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
